/* sv/s2i_pkg.sv */
`timescale 1ns / 1ps

package s2i_pkg;

  localparam int unsigned AccW     = 64;
  localparam int unsigned SumW     = 70;  // 2^63 * 36 + 35 fits
  localparam int unsigned BaseW    = 6;
  localparam int unsigned OffW     = 16;
  localparam int unsigned MacSteps = BaseW;
  localparam int unsigned StepW    = 3;
  localparam int unsigned PAddrW   = 3;
  localparam int unsigned PDataW   = 32;

  localparam logic [31:0] MaxOffsetDefault = 32'd65535;

  // register index is paddr[2]
  localparam logic RegIdxRadix = 1'b0;

  localparam logic [BaseW-1:0] RadixReset = 6'd10;
  localparam logic [BaseW-1:0] BaseAuto   = 6'd0;
  localparam logic [BaseW-1:0] BaseOne    = 6'd1;
  localparam logic [BaseW-1:0] BaseOct    = 6'd8;
  localparam logic [BaseW-1:0] BaseDec    = 6'd10;
  localparam logic [BaseW-1:0] BaseHex    = 6'd16;
  localparam logic [BaseW-1:0] BaseMax    = 6'd36;
  localparam logic [BaseW-1:0] DigitNone  = 6'd63;

  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChSpace  = 8'd32;
  localparam logic [7:0] ChPlus   = 8'd43;
  localparam logic [7:0] ChMinus  = 8'd45;
  localparam logic [7:0] ChZero   = 8'd48;
  localparam logic [7:0] ChNine   = 8'd57;
  localparam logic [7:0] ChUpperA = 8'd65;
  localparam logic [7:0] ChUpperX = 8'd88;
  localparam logic [7:0] ChUpperZ = 8'd90;
  localparam logic [7:0] ChLowerA = 8'd97;
  localparam logic [7:0] ChLowerX = 8'd120;
  localparam logic [7:0] ChLowerZ = 8'd122;

  localparam logic [AccW-1:0] Int64Max    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [AccW-1:0] Int64MinMag = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic signed [AccW-1:0] parsed_value;
    logic [OffW-1:0]        end_offset;
    logic                   has_digits;
    logic                   saturated;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [AccW-1:0]  acc;
    logic [BaseW-1:0] base;
    logic [BaseW-1:0] digit;
  } mac_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [AccW-1:0] value;
  } mac_rsp_t;

  // digit value of a character, DigitNone when it is no digit in any base
  function automatic logic [BaseW-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= ChZero && c <= ChNine) begin
      t = c - ChZero;
      return t[BaseW-1:0];
    end
    if (c >= ChLowerA && c <= ChLowerZ) begin
      t = c - ChLowerA + 8'd10;
      return t[BaseW-1:0];
    end
    if (c >= ChUpperA && c <= ChUpperZ) begin
      t = c - ChUpperA + 8'd10;
      return t[BaseW-1:0];
    end
    return DigitNone;
  endfunction

endpackage

/* sv/s2i_mac.sv */
`timescale 1ns / 1ps

module s2i_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  s2i_pkg::mac_req_t  req_i,
  output s2i_pkg::mac_rsp_t  rsp_o
);
  import s2i_pkg::*;

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SumW-1:0]  mcand_q, mcand_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [BaseW-1:0] mult_q, mult_d;
  logic             neg_q, neg_d;
  logic [SumW-1:0]  limit;
  logic             last;
  logic             ovf;

  assign last = busy_q && (step_q == StepW'(MacSteps));

  // shift-add over the base bits, digit preloaded into the sum
  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    mcand_d = mcand_q;
    sum_d   = sum_q;
    mult_d  = mult_q;
    neg_d   = neg_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      step_d  = '0;
      mcand_d = SumW'(req_i.acc);
      sum_d   = SumW'(req_i.digit);
      mult_d  = req_i.base;
      neg_d   = req_i.neg;
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        if (mult_q[0]) begin
          sum_d = sum_q + mcand_q;
        end
        mcand_d = mcand_q << 1;
        mult_d  = mult_q >> 1;
        step_d  = step_q + StepW'(1);
      end
    end
  end

  assign limit = neg_q ? SumW'(Int64MinMag) : SumW'(Int64Max);
  assign ovf   = sum_q > limit;

  assign rsp_o.done  = last;
  assign rsp_o.ovf   = ovf;
  assign rsp_o.value = ovf ? limit[AccW-1:0] : sum_q[AccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    sum_q   <= sum_d;
    mult_q  <= mult_d;
    neg_q   <= neg_d;
  end

endmodule

/* sv/string_to_int64_parser.sv */
// Streaming signed 64-bit integer parser.
// Input channel (in_valid_i / in_ready_o / in_i): one character per request;
// string_start marks the first character of a string, and the radix register
// is sampled then. Whitespace, one sign and a 0x prefix are taken as usual.
// Output channel (out_valid_o / out_ready_i / out_o): one result per string,
// sent on the character that ends the number (or at once for a bad base).
// A character that is not a digit is handled in its accept cycle, as is a digit
// once the value has clamped. Any other digit passes through the accept cycle,
// six shift-add steps of the shared multiply-accumulate unit (one per radix bit)
// and the range check and clamp; no new character is taken until it is done.
// A terminating character loads the output register in its accept cycle.
// While the result register is full and out_ready_i is low, no new character
// is taken; the held result stays until it is taken.
// Reset puts the parser in the done state (characters ignored until a
// string start), empties the output register and sets radix to 10.
// Configuration: APB register 0 (radix, 6 bits) at byte address 0, to be written
// only while the parser is idle; the block does not enforce this. pready is always high.
`timescale 1ns / 1ps

module string_to_int64_parser #(
  parameter logic [31:0] MAX_OFFSET = s2i_pkg::MaxOffsetDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  s2i_pkg::in_item_t            in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output s2i_pkg::out_item_t           out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [s2i_pkg::PAddrW-1:0]   paddr,
  input  logic [s2i_pkg::PDataW-1:0]   pwdata,
  output logic [s2i_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);
  import s2i_pkg::*;

  localparam logic [OffW-1:0] OffsetCap =
    (MAX_OFFSET < 32'd65535) ? MAX_OFFSET[OffW-1:0] : {OffW{1'b1}};

  localparam logic [2:0] PhDone   = 3'd0;
  localparam logic [2:0] PhSpace  = 3'd1;
  localparam logic [2:0] PhSigned = 3'd2;
  localparam logic [2:0] PhZero   = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;

  localparam logic StIdle = 1'b0;
  localparam logic StMac  = 1'b1;

  logic             state_q, state_d;
  logic [BaseW-1:0] radix_q, radix_d;
  logic [2:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [OffW-1:0]  pos_q, pos_d;
  logic             dseen_q, dseen_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             accept;
  logic             fin;
  logic             emit;
  logic             acc_clr;
  logic [BaseW-1:0] dval;
  logic [AccW-1:0]  acc_w;
  logic [AccW-1:0]  signed_val;
  logic             is_ws;
  logic [7:0]       c;
  mac_req_t         mac_req;
  mac_rsp_t         mac_rsp;

  function automatic logic [OffW-1:0] sat_inc(input logic [OffW-1:0] p);
    return (p < OffsetCap) ? p + OffW'(1) : p;
  endfunction

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_i.char_code;
  assign is_ws      = (c == ChSpace) || (c >= ChTab && c <= ChCr);
  assign dval       = digit_of(c);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    base_d      = base_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    dseen_d     = dseen_q;
    ovf_d       = ovf_q;
    fin         = 1'b0;
    emit        = 1'b0;
    acc_clr     = 1'b0;
    mac_req     = '0;

    if (accept) begin
      if (in_i.string_start) begin
        neg_d   = 1'b0;
        pos_d   = '0;
        dseen_d = 1'b0;
        ovf_d   = 1'b0;
        acc_clr = 1'b1;
        base_d  = radix_q;
        if (radix_q == BaseOne || radix_q > BaseMax) begin
          emit = 1'b1;
          fin  = 1'b1;
        end else begin
          phase_d = PhSpace;
        end
      end
      if (!fin && phase_d == PhDone) begin
        fin = 1'b1;
      end
      if (!fin && phase_d == PhSpace) begin
        if (is_ws) begin
          pos_d = sat_inc(pos_d);
          fin   = 1'b1;
        end else begin
          phase_d = PhSigned;
          if (c == ChMinus || c == ChPlus) begin
            neg_d = (c == ChMinus);
            pos_d = sat_inc(pos_d);
            fin   = 1'b1;
          end
        end
      end
      if (!fin && phase_d == PhSigned) begin
        if ((base_d == BaseAuto || base_d == BaseHex) && c == ChZero) begin
          pos_d   = sat_inc(pos_d);
          phase_d = PhZero;
          fin     = 1'b1;
        end else begin
          if (base_d == BaseAuto) begin
            base_d = BaseDec;
          end
          phase_d = PhDigits;
        end
      end
      if (!fin && phase_d == PhZero) begin
        phase_d = PhDigits;
        if (c == ChLowerX || c == ChUpperX) begin
          base_d = BaseHex;
          pos_d  = sat_inc(pos_d);
          fin    = 1'b1;
        end else begin
          if (base_d == BaseAuto) begin
            base_d = BaseOct;
          end
          // the leading zero counts as a digit; value stays zero
          dseen_d = 1'b1;
        end
      end
      if (!fin) begin
        if (dval < base_d) begin
          pos_d   = sat_inc(pos_d);
          dseen_d = 1'b1;
          if (!ovf_d) begin
            mac_req.start = 1'b1;
            state_d       = StMac;
          end
        end else begin
          emit = 1'b1;
        end
      end
      if (emit) begin
        phase_d = PhDone;
      end
      if (acc_clr) begin
        acc_d = '0;
      end
    end else if (state_q == StMac && mac_rsp.done) begin
      acc_d   = mac_rsp.value;
      ovf_d   = ovf_q | mac_rsp.ovf;
      state_d = StIdle;
    end

    mac_req.neg   = neg_d;
    mac_req.acc   = acc_clr ? '0 : acc_q;
    mac_req.base  = base_d;
    mac_req.digit = dval;
  end

  assign acc_w      = acc_clr ? '0 : acc_q;
  assign signed_val = neg_d ? (~acc_w + AccW'(1)) : acc_w;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d             = 1'b1;
      out_d.parsed_value      = dseen_d ? signed_val : '0;
      out_d.end_offset        = dseen_d ? pos_d : '0;
      out_d.has_digits        = dseen_d;
      out_d.saturated         = dseen_d && ovf_d;
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PAddrW-1] == RegIdxRadix) ? PDataW'(radix_q) : '0;

  always_comb begin
    radix_d = radix_q;
    if (psel && penable && pwrite && paddr[PAddrW-1] == RegIdxRadix) begin
      radix_d = pwdata[BaseW-1:0];
    end
  end

  s2i_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      radix_q     <= RadixReset;
      phase_q     <= PhDone;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      dseen_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      base_q      <= base_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      dseen_q     <= dseen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_mac_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_req.start |-> ##7 mac_rsp.done)
    else $error("multiply-accumulate did not finish in 7 cycles");

  a_sat_needs_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.saturated || out_o.has_digits))
    else $error("saturated result without digits");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.has_digits) |->
      (out_o.parsed_value == '0 && out_o.end_offset == '0))
    else $error("result without digits is not zero");

  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (phase_q == PhDone && state_q == StIdle))
    else $error("result sent while parse still open");
`endif

endmodule
